@@ rtl/core/ecol_pkg.sv @@
package ecol_pkg;

   // packed input item, first field in the lowest bits
   localparam int REQ_W = 352;

   localparam int LANES   = 4;
   localparam int LANE_1X = 0;
   localparam int LANE_1Y = 1;
   localparam int LANE_2X = 2;
   localparam int LANE_2Y = 3;

   // quotient bound: |delta| < 2^34 for every overlapping pair
   localparam int QUO_W        = 34;
   localparam int DEN_W        = 81;
   localparam int REM_W        = DEN_W;
   localparam int NUM_W        = REM_W + QUO_W;
   localparam int DIV_STEPS    = QUO_W;
   localparam int FRONT_STAGES = 9;

   typedef struct packed {
      logic [1:0]         pad;
      logic [30:0]        second_radius;
      logic [15:0]        second_mass;
      logic signed [31:0] second_vel_y;
      logic signed [31:0] second_vel_x;
      logic signed [31:0] second_pos_y;
      logic signed [31:0] second_pos_x;
      logic [30:0]        first_radius;
      logic [15:0]        first_mass;
      logic signed [31:0] first_vel_y;
      logic signed [31:0] first_vel_x;
      logic signed [31:0] first_pos_y;
      logic signed [31:0] first_pos_x;
   } ecol_req_type;

   typedef struct packed {
      logic               coincident;
      logic               collided;
      logic signed [31:0] new_second_vel_y;
      logic signed [31:0] new_second_vel_x;
      logic signed [31:0] new_first_vel_y;
      logic signed [31:0] new_first_vel_x;
   } ecol_rsp_type;

   // per-item control and pass-through velocities
   typedef struct packed {
      logic               hit;
      logic               coin;
      logic               sgn_x;
      logic               sgn_y;
      logic signed [31:0] v1x;
      logic signed [31:0] v1y;
      logic signed [31:0] v2x;
      logic signed [31:0] v2y;
   } ecol_side_type;

endpackage

@@ rtl/core/elastic_collision_2d.sv @@
// Elastic collision of two circular particles, one pair per clock unless
// stalled. A pair whose squared centre distance is below the squared sum of
// radii, with distinct centres and a nonzero mass sum, gets new velocities from
// the two-body elastic formula, rounded to nearest and saturated to Q16.16;
// other pairs pass their velocities through. Front stages form differences,
// squares and products, a 34-stage restoring divider forms four rounded
// quotients side by side, and back stages do sign, add and saturation. A single
// output register with a skid entry keeps req_tready high while one result waits.
module elastic_collision_2d (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass, first_radius,
   // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass,
   // second_radius, zero fill
   input  logic [ecol_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
   output logic [127:0]                 rsp_tdata,
   // collided, coincident
   output logic [1:0]                   rsp_tuser
);

   logic                                              en;
   ecol_pkg::ecol_req_type                            req;
   logic                                              f_valid, d_valid, b_valid;
   logic [ecol_pkg::DEN_W-1:0]                        f_den;
   logic [ecol_pkg::LANES-1:0][ecol_pkg::NUM_W-1:0]   f_num;
   logic [ecol_pkg::LANES-1:0][ecol_pkg::QUO_W-1:0]   d_quo;
   ecol_pkg::ecol_side_type                           f_side, d_side;
   ecol_pkg::ecol_rsp_type                            b_rsp;

   logic                   out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   ecol_pkg::ecol_rsp_type out_ff, out_in, skid_ff, skid_in;
   logic                   push, take;

   assign req = ecol_pkg::ecol_req_type'(req_tdata);
   assign en  = !skid_valid_ff;

   ecol_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (req_tvalid),
      .req_i   (req),
      .valid_o (f_valid),
      .den_o   (f_den),
      .num_o   (f_num),
      .side_o  (f_side)
   );

   ecol_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (f_valid),
      .den_i   (f_den),
      .num_i   (f_num),
      .side_i  (f_side),
      .valid_o (d_valid),
      .quo_o   (d_quo),
      .side_o  (d_side)
   );

   ecol_back u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (d_valid),
      .quo_i   (d_quo),
      .side_i  (d_side),
      .valid_o (b_valid),
      .rsp_o   (b_rsp)
   );

   assign push = en && b_valid;
   assign take = out_valid_ff && rsp_tready;

   // a pushed item lands in the skid entry only while the output register is held
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (out_valid_ff && !take) begin
            skid_valid_in = 1'b1;
            skid_in       = b_rsp;
         end else begin
            out_valid_in = 1'b1;
            out_in       = b_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.new_second_vel_y, out_ff.new_second_vel_x,
                        out_ff.new_first_vel_y, out_ff.new_first_vel_x};
   assign rsp_tuser  = {out_ff.coincident, out_ff.collided};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result both collided and coincident");
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input held off without a stalled result");
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry filled with output register empty");
`endif

endmodule

@@ rtl/core/ecol_front.sv @@
module ecol_front (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                en,
   input  logic                                                valid_i,
   input  ecol_pkg::ecol_req_type                              req_i,
   output logic                                                valid_o,
   output logic [ecol_pkg::DEN_W-1:0]                          den_o,
   output logic [ecol_pkg::LANES-1:0][ecol_pkg::NUM_W-1:0]     num_o,
   output ecol_pkg::ecol_side_type                             side_o
);

   function automatic logic [31:0] mag33(logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   logic [ecol_pkg::FRONT_STAGES-1:0] val_ff;
   ecol_pkg::ecol_side_type           side_ff [ecol_pkg::FRONT_STAGES];
   ecol_pkg::ecol_side_type           side1_w, side3_w, side4_w;

   logic signed [32:0] dx_w, dy_w, dvx_w, dvy_w;

   // stage 1
   logic [31:0] dxm1_ff, dym1_ff, dvxm1_ff, dvym1_ff, rs1_ff;
   logic        dxn1_ff, dyn1_ff, dvxn1_ff, dvyn1_ff;
   logic [15:0] ma1_ff, mb1_ff;
   // stage 2
   logic [63:0] sqx2_ff, sqy2_ff, rsq2_ff, px2_ff, py2_ff;
   logic        sx2_ff, sy2_ff, dxn2_ff, dyn2_ff;
   logic [31:0] dxm2_ff, dym2_ff;
   logic [15:0] ma2_ff, mb2_ff;
   logic [16:0] ms2_ff;
   // stage 3
   logic [64:0]        d2_w;
   logic signed [65:0] tx_w, ty_w;
   logic [63:0]        d23_ff;
   logic signed [65:0] dot3_ff;
   logic               dxn3_ff, dyn3_ff;
   logic [31:0]        dxm3_ff, dym3_ff;
   logic [15:0]        ma3_ff, mb3_ff;
   logic [16:0]        ms3_ff;
   // stage 4
   logic signed [65:0] dotn_w;
   logic [64:0]        pmag_w;
   logic [64:0]        pm4_ff;
   logic [48:0]        dlo4_ff, dhi4_ff;
   logic [31:0]        dxm4_ff, dym4_ff;
   logic [15:0]        ma4_ff, mb4_ff;
   // stage 5
   logic [80:0] den5_ff;
   logic [63:0] pax5_ff, pay5_ff;
   logic [64:0] pbx5_ff, pby5_ff;
   logic [15:0] ma5_ff, mb5_ff;
   // stage 6
   logic [80:0] den6_ff;
   logic [96:0] prx6_ff, pry6_ff;
   logic [15:0] ma6_ff, mb6_ff;
   // stage 7
   logic [80:0] den7_ff;
   logic [ecol_pkg::LANES-1:0][2:0][48:0] part7_ff;
   logic [ecol_pkg::LANES-1:0][2:0][48:0] part7_in;
   // stage 8, 9
   logic [80:0]                                       den8_ff, den9_ff;
   logic [ecol_pkg::LANES-1:0][112:0]                 sum8_ff;
   logic [ecol_pkg::LANES-1:0][ecol_pkg::NUM_W-1:0]   num9_ff;

   assign dx_w  = $signed({req_i.first_pos_x[31], req_i.first_pos_x})
                - $signed({req_i.second_pos_x[31], req_i.second_pos_x});
   assign dy_w  = $signed({req_i.first_pos_y[31], req_i.first_pos_y})
                - $signed({req_i.second_pos_y[31], req_i.second_pos_y});
   assign dvx_w = $signed({req_i.first_vel_x[31], req_i.first_vel_x})
                - $signed({req_i.second_vel_x[31], req_i.second_vel_x});
   assign dvy_w = $signed({req_i.first_vel_y[31], req_i.first_vel_y})
                - $signed({req_i.second_vel_y[31], req_i.second_vel_y});

   always_comb begin
      side1_w      = '0;
      side1_w.coin = (req_i.first_pos_x == req_i.second_pos_x) &&
                     (req_i.first_pos_y == req_i.second_pos_y);
      side1_w.v1x  = req_i.first_vel_x;
      side1_w.v1y  = req_i.first_vel_y;
      side1_w.v2x  = req_i.second_vel_x;
      side1_w.v2y  = req_i.second_vel_y;
   end

   assign d2_w = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
   assign tx_w = sx2_ff ? -$signed({2'b00, px2_ff}) : $signed({2'b00, px2_ff});
   assign ty_w = sy2_ff ? -$signed({2'b00, py2_ff}) : $signed({2'b00, py2_ff});

   always_comb begin
      side3_w     = side_ff[1];
      side3_w.hit = (d2_w < {1'b0, rsq2_ff}) && !side_ff[1].coin && (ms2_ff != 17'd0);
   end

   assign dotn_w = -dot3_ff;
   assign pmag_w = dot3_ff[65] ? dotn_w[64:0] : dot3_ff[64:0];

   always_comb begin
      side4_w       = side_ff[2];
      side4_w.sgn_x = dot3_ff[65] ^ dxn3_ff;
      side4_w.sgn_y = dot3_ff[65] ^ dyn3_ff;
   end

   // split each product by the mass into three chunk products
   always_comb begin
      for (int l = 0; l < ecol_pkg::LANES; l++) begin
         logic [96:0] p;
         logic [15:0] m;
         p = (l == ecol_pkg::LANE_1X || l == ecol_pkg::LANE_2X) ? prx6_ff : pry6_ff;
         m = (l == ecol_pkg::LANE_1X || l == ecol_pkg::LANE_1Y) ? mb6_ff : ma6_ff;
         part7_in[l][0] = {17'd0, p[31:0]}  * {33'd0, m};
         part7_in[l][1] = {17'd0, p[63:32]} * {33'd0, m};
         part7_in[l][2] = {16'd0, p[96:64]} * {33'd0, m};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[ecol_pkg::FRONT_STAGES-2:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side1_w;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side3_w;
         side_ff[3] <= side4_w;
         for (int k = 4; k < ecol_pkg::FRONT_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end

         dxm1_ff  <= mag33(dx_w);
         dym1_ff  <= mag33(dy_w);
         dvxm1_ff <= mag33(dvx_w);
         dvym1_ff <= mag33(dvy_w);
         dxn1_ff  <= dx_w[32];
         dyn1_ff  <= dy_w[32];
         dvxn1_ff <= dvx_w[32];
         dvyn1_ff <= dvy_w[32];
         rs1_ff   <= {1'b0, req_i.first_radius} + {1'b0, req_i.second_radius};
         ma1_ff   <= req_i.first_mass;
         mb1_ff   <= req_i.second_mass;

         sqx2_ff <= {32'd0, dxm1_ff} * {32'd0, dxm1_ff};
         sqy2_ff <= {32'd0, dym1_ff} * {32'd0, dym1_ff};
         rsq2_ff <= {32'd0, rs1_ff} * {32'd0, rs1_ff};
         px2_ff  <= {32'd0, dvxm1_ff} * {32'd0, dxm1_ff};
         py2_ff  <= {32'd0, dvym1_ff} * {32'd0, dym1_ff};
         sx2_ff  <= dvxn1_ff ^ dxn1_ff;
         sy2_ff  <= dvyn1_ff ^ dyn1_ff;
         dxn2_ff <= dxn1_ff;
         dyn2_ff <= dyn1_ff;
         dxm2_ff <= dxm1_ff;
         dym2_ff <= dym1_ff;
         ma2_ff  <= ma1_ff;
         mb2_ff  <= mb1_ff;
         ms2_ff  <= {1'b0, ma1_ff} + {1'b0, mb1_ff};

         d23_ff  <= d2_w[63:0];
         dot3_ff <= tx_w + ty_w;
         dxn3_ff <= dxn2_ff;
         dyn3_ff <= dyn2_ff;
         dxm3_ff <= dxm2_ff;
         dym3_ff <= dym2_ff;
         ma3_ff  <= ma2_ff;
         mb3_ff  <= mb2_ff;
         ms3_ff  <= ms2_ff;

         pm4_ff  <= pmag_w;
         dlo4_ff <= {17'd0, d23_ff[31:0]} * {32'd0, ms3_ff};
         dhi4_ff <= {17'd0, d23_ff[63:32]} * {32'd0, ms3_ff};
         dxm4_ff <= dxm3_ff;
         dym4_ff <= dym3_ff;
         ma4_ff  <= ma3_ff;
         mb4_ff  <= mb3_ff;

         den5_ff <= {32'd0, dlo4_ff} + {dhi4_ff, 32'd0};
         pax5_ff <= {32'd0, pm4_ff[31:0]} * {32'd0, dxm4_ff};
         pay5_ff <= {32'd0, pm4_ff[31:0]} * {32'd0, dym4_ff};
         pbx5_ff <= {32'd0, pm4_ff[64:32]} * {33'd0, dxm4_ff};
         pby5_ff <= {32'd0, pm4_ff[64:32]} * {33'd0, dym4_ff};
         ma5_ff  <= ma4_ff;
         mb5_ff  <= mb4_ff;

         den6_ff <= den5_ff;
         prx6_ff <= {33'd0, pax5_ff} + {pbx5_ff, 32'd0};
         pry6_ff <= {33'd0, pay5_ff} + {pby5_ff, 32'd0};
         ma6_ff  <= ma5_ff;
         mb6_ff  <= mb5_ff;

         den7_ff  <= den6_ff;
         part7_ff <= part7_in;

         den8_ff <= den7_ff;
         for (int l = 0; l < ecol_pkg::LANES; l++) begin
            sum8_ff[l] <= {64'd0, part7_ff[l][0]} + {32'd0, part7_ff[l][1], 32'd0}
                        + {part7_ff[l][2], 64'd0};
         end

         // double the product and add half the divisor for round-to-nearest
         den9_ff <= den8_ff;
         for (int l = 0; l < ecol_pkg::LANES; l++) begin
            num9_ff[l] <= {1'b0, sum8_ff[l], 1'b0} + {35'd0, den8_ff[80:1]};
         end
      end
   end

   assign valid_o = val_ff[ecol_pkg::FRONT_STAGES-1];
   assign den_o   = den9_ff;
   assign num_o   = num9_ff;
   assign side_o  = side_ff[ecol_pkg::FRONT_STAGES-1];

endmodule

@@ rtl/core/ecol_div.sv @@
module ecol_div (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                en,
   input  logic                                                valid_i,
   input  logic [ecol_pkg::DEN_W-1:0]                          den_i,
   input  logic [ecol_pkg::LANES-1:0][ecol_pkg::NUM_W-1:0]     num_i,
   input  ecol_pkg::ecol_side_type                             side_i,
   output logic                                                valid_o,
   output logic [ecol_pkg::LANES-1:0][ecol_pkg::QUO_W-1:0]     quo_o,
   output ecol_pkg::ecol_side_type                             side_o
);

   localparam int LAST = ecol_pkg::DIV_STEPS - 1;

   logic [ecol_pkg::DIV_STEPS-1:0]   val_ff;
   logic [ecol_pkg::DEN_W-1:0]       den_ff  [ecol_pkg::DIV_STEPS];
   logic [ecol_pkg::DEN_W-1:0]       den_src [ecol_pkg::DIV_STEPS];
   ecol_pkg::ecol_side_type          side_ff [ecol_pkg::DIV_STEPS];

   logic [ecol_pkg::LANES-1:0][ecol_pkg::REM_W-1:0] rem_ff  [ecol_pkg::DIV_STEPS];
   logic [ecol_pkg::LANES-1:0][ecol_pkg::REM_W-1:0] rem_in  [ecol_pkg::DIV_STEPS];
   logic [ecol_pkg::LANES-1:0][ecol_pkg::REM_W-1:0] rem_src [ecol_pkg::DIV_STEPS];
   logic [ecol_pkg::LANES-1:0][ecol_pkg::QUO_W-1:0] low_ff  [ecol_pkg::DIV_STEPS];
   logic [ecol_pkg::LANES-1:0][ecol_pkg::QUO_W-1:0] low_in  [ecol_pkg::DIV_STEPS];
   logic [ecol_pkg::LANES-1:0][ecol_pkg::QUO_W-1:0] low_src [ecol_pkg::DIV_STEPS];

   for (genvar k = 0; k < ecol_pkg::DIV_STEPS; k++) begin : g_src
      if (k == 0) begin : g_first
         assign den_src[k] = den_i;
         for (genvar l = 0; l < ecol_pkg::LANES; l++) begin : g_lane
            assign rem_src[k][l] = num_i[l][ecol_pkg::NUM_W-1:ecol_pkg::QUO_W];
            assign low_src[k][l] = num_i[l][ecol_pkg::QUO_W-1:0];
         end
      end else begin : g_next
         assign den_src[k] = den_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign low_src[k] = low_ff[k-1];
      end
   end

   // one restoring step per stage: shift in the next dividend bit, trial subtract
   always_comb begin
      logic [ecol_pkg::REM_W:0] t;
      logic [ecol_pkg::REM_W:0] td;
      for (int k = 0; k < ecol_pkg::DIV_STEPS; k++) begin
         for (int l = 0; l < ecol_pkg::LANES; l++) begin
            t  = {rem_src[k][l], low_src[k][l][ecol_pkg::QUO_W-1]};
            td = t - {1'b0, den_src[k]};
            if (t >= {1'b0, den_src[k]}) begin
               rem_in[k][l] = td[ecol_pkg::REM_W-1:0];
               low_in[k][l] = {low_src[k][l][ecol_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = t[ecol_pkg::REM_W-1:0];
               low_in[k][l] = {low_src[k][l][ecol_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[ecol_pkg::DIV_STEPS-2:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_i;
         for (int k = 0; k < ecol_pkg::DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_src[k];
         end
         for (int k = 1; k < ecol_pkg::DIV_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign valid_o = val_ff[LAST];
   assign quo_o   = low_ff[LAST];
   assign side_o  = side_ff[LAST];

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      valid_o && side_o.hit |->
         (rem_ff[LAST][ecol_pkg::LANE_1X] < den_ff[LAST]) &&
         (rem_ff[LAST][ecol_pkg::LANE_1Y] < den_ff[LAST]) &&
         (rem_ff[LAST][ecol_pkg::LANE_2X] < den_ff[LAST]) &&
         (rem_ff[LAST][ecol_pkg::LANE_2Y] < den_ff[LAST]))
      else $error("divider remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset)
      valid_o && side_o.coin |-> !side_o.hit)
      else $error("coincident pair marked as a collision");
`endif

endmodule

@@ rtl/core/ecol_back.sv @@
module ecol_back (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                en,
   input  logic                                                valid_i,
   input  logic [ecol_pkg::LANES-1:0][ecol_pkg::QUO_W-1:0]     quo_i,
   input  ecol_pkg::ecol_side_type                             side_i,
   output logic                                                valid_o,
   output ecol_pkg::ecol_rsp_type                              rsp_o
);

   localparam int DLT_W = ecol_pkg::QUO_W + 1;
   localparam int SUM_W = DLT_W + 1;

   function automatic logic signed [31:0] sat32(logic signed [SUM_W-1:0] s);
      logic [SUM_W-32:0] top;
      top = s[SUM_W-1:31];
      if (top == '0 || top == '1) begin
         return s[31:0];
      end else if (s[SUM_W-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_v(logic signed [31:0] v);
      return $signed({{(SUM_W-32){v[31]}}, v});
   endfunction

   function automatic logic signed [SUM_W-1:0] ext_d(logic signed [DLT_W-1:0] d);
      return $signed({d[DLT_W-1], d});
   endfunction

   logic [1:0]                       val_ff;
   logic signed [DLT_W-1:0]          dlt_ff [ecol_pkg::LANES];
   logic signed [DLT_W-1:0]          dlt_in [ecol_pkg::LANES];
   ecol_pkg::ecol_side_type          side_ff;
   ecol_pkg::ecol_rsp_type           rsp_ff, rsp_in;
   logic signed [SUM_W-1:0]          s1x_w, s1y_w, s2x_w, s2y_w;

   // apply the sign of dot product times the distance component
   always_comb begin
      logic                    neg;
      logic signed [DLT_W-1:0] mag;
      for (int l = 0; l < ecol_pkg::LANES; l++) begin
         neg = (l == ecol_pkg::LANE_1X || l == ecol_pkg::LANE_2X) ?
               side_i.sgn_x : side_i.sgn_y;
         mag = $signed({1'b0, quo_i[l]});
         dlt_in[l] = neg ? -mag : mag;
      end
   end

   assign s1x_w = ext_v(side_ff.v1x) - ext_d(dlt_ff[ecol_pkg::LANE_1X]);
   assign s1y_w = ext_v(side_ff.v1y) - ext_d(dlt_ff[ecol_pkg::LANE_1Y]);
   assign s2x_w = ext_v(side_ff.v2x) + ext_d(dlt_ff[ecol_pkg::LANE_2X]);
   assign s2y_w = ext_v(side_ff.v2y) + ext_d(dlt_ff[ecol_pkg::LANE_2Y]);

   always_comb begin
      rsp_in.coincident       = side_ff.coin;
      rsp_in.collided         = side_ff.hit;
      rsp_in.new_first_vel_x  = side_ff.hit ? sat32(s1x_w) : side_ff.v1x;
      rsp_in.new_first_vel_y  = side_ff.hit ? sat32(s1y_w) : side_ff.v1y;
      rsp_in.new_second_vel_x = side_ff.hit ? sat32(s2x_w) : side_ff.v2x;
      rsp_in.new_second_vel_y = side_ff.hit ? sat32(s2y_w) : side_ff.v2y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dlt_ff  <= dlt_in;
         side_ff <= side_i;
         rsp_ff  <= rsp_in;
      end
   end

   assign valid_o = val_ff[1];
   assign rsp_o   = rsp_ff;

endmodule
